/* sv/tpt_pkg.sv */
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types, codes and defaults for the TLB page translator.
// ----------------------------------------------------------------------------
package tpt_pkg;

  // Default sizing
  localparam int TLB_ENTRIES_DEF = 16;
  localparam int FRAME_COUNT_DEF = 16;
  localparam int PAGE_COUNT_DEF  = 64;
  localparam int OFFSET_BITS_DEF = 10;

  // Fixed field widths
  localparam int FUNC_W   = 2;
  localparam int VADDR_W  = 16;
  localparam int VPAGE_W  = 6;
  localparam int STATUS_W = 3;
  localparam int PADDR_W  = 14;
  localparam int FRAME_W  = 4;
  localparam int COUNT_W  = 16;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_TRANSLATE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MAP       = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE   = 2'd2;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    RES_TLB_HIT        = 3'd0,
    RES_TABLE_HIT      = 3'd1,
    RES_FAULT_OK       = 3'd2,
    RES_FAULT_NO_FRAME = 3'd3,
    RES_MAPPED         = 3'd4,
    RES_MAP_NO_FRAME   = 3'd5,
    RES_RELEASED       = 3'd6
  } res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_LOOK,
    ST_RESOLVE,
    ST_RELEASE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic reduce_step;
    logic clr_step;
    logic resolve;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] in_func;
    logic              reduce_last;
    logic              clr_last;
    logic              out_busy;
  } stat_t;

  function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] v);
    return (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

/* sv/tlb_page_translator_core.sv */
// ----------------------------------------------------------------------------
// tlb_page_translator_core
// Translate/map/release engine: fully associative TLB in front of a page
// table RAM, frames handed out lowest first, saturating statistics.
//
// Sequence: translate and map look up TLB and table at accept and resolve
//   next when PAGE_COUNT is a power of two; otherwise two reduce steps
//   (multiply, subtract) and a lookup state come first. Resolve waits
//   while an untaken result word is held; a new request is taken only
//   after resolve. Release sweeps the table one entry per cycle first.
// Reset: synchronous; afterwards the table RAM is swept with s_tready low
//   before the first word is taken.
// ----------------------------------------------------------------------------
module tlb_page_translator_core #(
  parameter int TLB_ENTRIES = tpt_pkg::TLB_ENTRIES_DEF,
  parameter int FRAME_COUNT = tpt_pkg::FRAME_COUNT_DEF,
  parameter int PAGE_COUNT  = tpt_pkg::PAGE_COUNT_DEF,
  parameter int OFFSET_BITS = tpt_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] virtual_address, [21:16] virtual_page
  input  logic [1:0]  s_tuser,   // [1:0] func
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [13:0] physical_address, [17:14] frame,
                                 // [33:18] tlb_hit_count, [49:34] fault_count,
                                 // [65:50] access_count
  output logic [2:0]  m_tuser    // [2:0] status
);

  tpt_pkg::cmd_t  cmd;
  tpt_pkg::stat_t stat;

  tpt_pkg::res_t                       out_status;
  logic [tpt_pkg::PADDR_W-1:0]         out_pa;
  logic [tpt_pkg::FRAME_W-1:0]         out_frame;
  logic [tpt_pkg::COUNT_W-1:0]         out_hit, out_fault, out_acc;

  // Sequencer: owns s_tready, steps the datapath through each request
  tpt_ctrl #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // TLB, page table, frame allocation and result register
  tpt_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .FRAME_COUNT (FRAME_COUNT),
    .PAGE_COUNT  (PAGE_COUNT),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (s_tuser),
    .in_va      (s_tdata[15:0]),
    .in_vpage   (s_tdata[21:16]),
    .m_tready   (m_tready),
    .out_valid  (m_tvalid),
    .out_status (out_status),
    .out_pa     (out_pa),
    .out_frame  (out_frame),
    .out_hit    (out_hit),
    .out_fault  (out_fault),
    .out_acc    (out_acc)
  );

  // Result word packing, padded to whole bytes
  assign m_tdata = {6'd0, out_acc, out_fault, out_hit, out_frame, out_pa};
  assign m_tuser = out_status;

endmodule

/* sv/tpt_ram.sv */
// ----------------------------------------------------------------------------
// tpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/tpt_ctrl.sv */
// ----------------------------------------------------------------------------
// tpt_ctrl
// Sequencer: clearing sweep, page reduction steps, lookup and resolve.
// ----------------------------------------------------------------------------
module tpt_ctrl #(
  parameter int PAGE_COUNT = tpt_pkg::PAGE_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output tpt_pkg::cmd_t cmd,
  input  tpt_pkg::stat_t stat
);

  // Power-of-two page count: page is a plain mask, no reduction needed
  localparam bit PAGE_POW2 = ((PAGE_COUNT & (PAGE_COUNT - 1)) == 0);

  tpt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      tpt_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = tpt_pkg::ST_IDLE;
        end
      end
      tpt_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          case (stat.in_func)
            tpt_pkg::FUNC_TRANSLATE, tpt_pkg::FUNC_MAP: begin
              state_next = PAGE_POW2 ? tpt_pkg::ST_RESOLVE : tpt_pkg::ST_REDUCE;
            end
            tpt_pkg::FUNC_RELEASE: begin
              state_next = tpt_pkg::ST_RELEASE;
            end
            default: begin
              state_next = tpt_pkg::ST_IDLE;  // unused code: dropped
            end
          endcase
        end
      end
      tpt_pkg::ST_REDUCE: begin
        cmd.reduce_step = 1'b1;
        if (stat.reduce_last) begin
          state_next = tpt_pkg::ST_LOOK;
        end
      end
      tpt_pkg::ST_LOOK: begin
        state_next = tpt_pkg::ST_RESOLVE;
      end
      tpt_pkg::ST_RESOLVE: begin
        if (!stat.out_busy) begin
          cmd.resolve = 1'b1;
          state_next  = tpt_pkg::ST_IDLE;
        end
      end
      tpt_pkg::ST_RELEASE: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = tpt_pkg::ST_RESOLVE;
        end
      end
      default: begin
        state_next = tpt_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_reduce_pow2: assert property (@(posedge clk) disable iff (rst)
    cmd.reduce_step |-> !PAGE_POW2)
    else $error("reduction step with power-of-two page count");

  a_clear_then_resolve: assert property (@(posedge clk) disable iff (rst)
    (state == tpt_pkg::ST_RELEASE && stat.clr_last) |=> state == tpt_pkg::ST_RESOLVE)
    else $error("release sweep did not end in resolve");
`endif

endmodule

/* sv/tpt_datapath.sv */
// ----------------------------------------------------------------------------
// tpt_datapath
// TLB entries, page table RAM, frame fill count, counters, output register.
// ----------------------------------------------------------------------------
module tpt_datapath #(
  parameter int TLB_ENTRIES = tpt_pkg::TLB_ENTRIES_DEF,
  parameter int FRAME_COUNT = tpt_pkg::FRAME_COUNT_DEF,
  parameter int PAGE_COUNT  = tpt_pkg::PAGE_COUNT_DEF,
  parameter int OFFSET_BITS = tpt_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tpt_pkg::cmd_t                   cmd,
  output tpt_pkg::stat_t                  stat,
  input  logic [tpt_pkg::FUNC_W-1:0]      in_func,
  input  logic [tpt_pkg::VADDR_W-1:0]     in_va,
  input  logic [tpt_pkg::VPAGE_W-1:0]     in_vpage,
  input  logic                            m_tready,
  output logic                            out_valid,
  output tpt_pkg::res_t                   out_status,
  output logic [tpt_pkg::PADDR_W-1:0]     out_pa,
  output logic [tpt_pkg::FRAME_W-1:0]     out_frame,
  output logic [tpt_pkg::COUNT_W-1:0]     out_hit,
  output logic [tpt_pkg::COUNT_W-1:0]     out_fault,
  output logic [tpt_pkg::COUNT_W-1:0]     out_acc
);

  localparam int TLB_W  = $clog2(TLB_ENTRIES);
  localparam int FR_W   = $clog2(FRAME_COUNT);
  localparam int USED_W = $clog2(FRAME_COUNT + 1);
  localparam int PAGE_W = $clog2(PAGE_COUNT);
  localparam int RAW_W  = tpt_pkg::VADDR_W - OFFSET_BITS;
  localparam int WORK_A = (RAW_W > tpt_pkg::VPAGE_W) ? RAW_W : tpt_pkg::VPAGE_W;
  localparam int WORK_W = (WORK_A > PAGE_W) ? WORK_A : PAGE_W;
  // Page modulo by reciprocal multiply: exact for any WORK_W-bit page
  localparam int RED_SHIFT = WORK_W + PAGE_W;
  localparam int RECIP_W   = WORK_W + 2;
  localparam int PROD_W    = WORK_W + RECIP_W;
  localparam logic [PROD_W-1:0] RECIP =
    PROD_W'(((64'd1 << RED_SHIFT) + 64'(PAGE_COUNT) - 64'd1) / 64'(PAGE_COUNT));
  localparam logic [tpt_pkg::VADDR_W-1:0] OFF_MASK =
    tpt_pkg::VADDR_W'((32'h1 << OFFSET_BITS) - 32'h1);

  // Latched request
  logic [tpt_pkg::FUNC_W-1:0]  func_q;
  logic [tpt_pkg::VADDR_W-1:0] offset_q;
  logic [WORK_W-1:0]           work_q;
  logic [WORK_W-1:0]           quot_q;
  logic                        red_half_q;
  logic [PROD_W-1:0]           recip_prod, quot_full, back_prod;
  logic [WORK_W-1:0]           raw;
  logic [PAGE_W-1:0]           page_q;
  logic [PAGE_W-1:0]           look_page;

  // TLB
  logic [PAGE_W-1:0]      tlb_page  [TLB_ENTRIES];
  logic [FR_W-1:0]        tlb_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid;
  logic [TLB_W-1:0]       tlb_ptr;
  logic [TLB_ENTRIES-1:0] match_q;

  // Frames, counters, clear sweep
  logic [USED_W-1:0]           used_cnt;
  logic [tpt_pkg::COUNT_W-1:0] hit_cnt, fault_cnt, acc_cnt;
  logic [tpt_pkg::COUNT_W-1:0] hit_next, fault_next, acc_next;
  logic [PAGE_W-1:0]           clr_addr;

  // Page table RAM: {valid, frame}
  logic              ram_we;
  logic [PAGE_W-1:0] ram_waddr;
  logic [FR_W:0]     ram_wdata;
  logic [FR_W:0]     ram_rdata;

  // Resolve decode
  logic               hit_any;
  logic [TLB_W-1:0]   hit_idx;
  logic               frame_free;
  logic [FR_W-1:0]    free_frame;
  tpt_pkg::res_t      r_status;
  logic [FR_W-1:0]    r_frame;
  logic               r_xlate, do_alloc, do_fill, do_hit, do_fault, do_acc, do_clear;
  logic [31:0]        pa_wide, frame_wide;

  assign raw = (in_func == tpt_pkg::FUNC_MAP) ? WORK_W'(in_vpage)
                                               : WORK_W'(in_va >> OFFSET_BITS);
  assign page_q    = work_q[PAGE_W-1:0];
  // At accept the lookup runs straight off the incoming page
  assign look_page = cmd.load ? raw[PAGE_W-1:0] : page_q;

  // First step: quotient; second step: subtract quotient times page count
  assign recip_prod = PROD_W'(work_q) * RECIP;
  assign quot_full  = recip_prod >> RED_SHIFT;
  assign back_prod  = PROD_W'(quot_q) * PROD_W'(PAGE_COUNT);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q     <= in_func;
      offset_q   <= in_va & OFF_MASK;
      work_q     <= raw;
      red_half_q <= 1'b0;
    end else if (cmd.reduce_step) begin
      if (red_half_q) begin
        work_q <= work_q - back_prod[WORK_W-1:0];
      end else begin
        quot_q <= quot_full[WORK_W-1:0];
      end
      red_half_q <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match_q[i] <= tlb_valid[i] && (tlb_page[i] == look_page);
    end
  end

  tpt_ram #(
    .WIDTH (FR_W + 1),
    .DEPTH (PAGE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (look_page),
    .rdata (ram_rdata)
  );

  assign frame_free = used_cnt < USED_W'(FRAME_COUNT);
  assign free_frame = used_cnt[FR_W-1:0];
  assign hit_any    = |match_q;

  // lowest matching entry wins
  always_comb begin
    hit_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx = TLB_W'(i);
      end
    end
  end

  always_comb begin
    r_status = tpt_pkg::RES_RELEASED;
    r_frame  = '0;
    r_xlate  = 1'b0;
    do_alloc = 1'b0;
    do_fill  = 1'b0;
    do_hit   = 1'b0;
    do_fault = 1'b0;
    do_acc   = 1'b0;
    do_clear = 1'b0;
    case (func_q)
      tpt_pkg::FUNC_TRANSLATE: begin
        do_acc = 1'b1;
        if (hit_any) begin
          r_status = tpt_pkg::RES_TLB_HIT;
          r_frame  = tlb_frame[hit_idx];
          r_xlate  = 1'b1;
          do_hit   = 1'b1;
        end else if (ram_rdata[FR_W]) begin
          r_status = tpt_pkg::RES_TABLE_HIT;
          r_frame  = ram_rdata[FR_W-1:0];
          r_xlate  = 1'b1;
          do_fill  = 1'b1;
        end else begin
          do_fault = 1'b1;
          if (frame_free) begin
            r_status = tpt_pkg::RES_FAULT_OK;
            r_frame  = free_frame;
            r_xlate  = 1'b1;
            do_fill  = 1'b1;
            do_alloc = 1'b1;
          end else begin
            r_status = tpt_pkg::RES_FAULT_NO_FRAME;
          end
        end
      end
      tpt_pkg::FUNC_MAP: begin
        if (frame_free) begin
          r_status = tpt_pkg::RES_MAPPED;
          r_frame  = free_frame;
          do_alloc = 1'b1;
        end else begin
          r_status = tpt_pkg::RES_MAP_NO_FRAME;
        end
      end
      default: begin
        do_clear = 1'b1;
      end
    endcase
  end

  assign hit_next   = do_clear ? '0 : (do_hit   ? tpt_pkg::sat_inc(hit_cnt)   : hit_cnt);
  assign fault_next = do_clear ? '0 : (do_fault ? tpt_pkg::sat_inc(fault_cnt) : fault_cnt);
  assign acc_next   = do_clear ? '0 : (do_acc   ? tpt_pkg::sat_inc(acc_cnt)   : acc_cnt);

  assign pa_wide    = (32'(r_frame) << OFFSET_BITS) | 32'(offset_q);
  assign frame_wide = 32'(r_frame);

  // RAM write: clear sweep or a new mapping
  assign ram_we    = cmd.clr_step || (cmd.resolve && do_alloc);
  assign ram_waddr = cmd.clr_step ? clr_addr : page_q;
  assign ram_wdata = cmd.clr_step ? '0 : {1'b1, free_frame};

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= (clr_addr == PAGE_W'(PAGE_COUNT - 1)) ? '0 : clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_valid <= '0;
      tlb_ptr   <= '0;
      used_cnt  <= '0;
      hit_cnt   <= '0;
      fault_cnt <= '0;
      acc_cnt   <= '0;
    end else if (cmd.resolve) begin
      hit_cnt   <= hit_next;
      fault_cnt <= fault_next;
      acc_cnt   <= acc_next;
      if (do_clear) begin
        tlb_valid <= '0;
        used_cnt  <= '0;
      end
      if (do_alloc) begin
        used_cnt <= used_cnt + 1'b1;
      end
      if (do_fill) begin
        tlb_valid[tlb_ptr] <= 1'b1;
        tlb_ptr <= (tlb_ptr == TLB_W'(TLB_ENTRIES - 1)) ? '0 : tlb_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve && do_fill) begin
      tlb_page[tlb_ptr]  <= page_q;
      tlb_frame[tlb_ptr] <= r_frame;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resolve) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      out_status <= r_status;
      out_pa     <= r_xlate ? pa_wide[tpt_pkg::PADDR_W-1:0] : '0;
      out_frame  <= frame_wide[tpt_pkg::FRAME_W-1:0];
      out_hit    <= hit_next;
      out_fault  <= fault_next;
      out_acc    <= acc_next;
    end
  end

  assign stat.in_func     = in_func;
  assign stat.reduce_last = red_half_q;
  assign stat.clr_last    = (clr_addr == PAGE_W'(PAGE_COUNT - 1));
  assign stat.out_busy    = out_valid && !m_tready;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_cnt <= USED_W'(FRAME_COUNT))
    else $error("frame fill count beyond frame count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.resolve |-> !(out_valid && !m_tready))
    else $error("result loaded over an untaken word");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.resolve |=> out_valid)
    else $error("resolved result not presented");

  a_clear_only_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.resolve && do_clear) |=> (used_cnt == '0 && tlb_valid == '0))
    else $error("release left frames or TLB entries behind");
`endif

endmodule

/* tb/sv/tlb_page_translator_checker.sv */
// ----------------------------------------------------------------------------
// tlb_page_translator_checker
// Watches both word channels of the translator, predicts each result word
// from the accepted requests and compares every field in order.
// ----------------------------------------------------------------------------
module tlb_page_translator_checker
  import tpt_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic [2:0]  m_tuser,
  output int          errors,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    res_t               status;
    logic [PADDR_W-1:0] paddr;
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] faults;
    logic [COUNT_W-1:0] accesses;
  } outcome_t;

  // shadow of the translator state
  logic [VPAGE_W-1:0] tlb_pg    [TLB_ENTRIES];
  logic [FRAME_W-1:0] tlb_fr    [TLB_ENTRIES];
  bit                 tlb_v     [TLB_ENTRIES];
  int                 tlb_next;
  bit                 tbl_v     [PAGE_COUNT];
  logic [FRAME_W-1:0] tbl_fr    [PAGE_COUNT];
  bit                 frame_busy[FRAME_COUNT];
  logic [COUNT_W-1:0] hits, faults, accesses;

  outcome_t outcome_q[$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  function automatic logic [COUNT_W-1:0] count_up(logic [COUNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // FRAME_COUNT when every frame is taken
  function automatic int first_free_frame();
    for (int f = 0; f < FRAME_COUNT; f++)
      if (!frame_busy[f]) return f;
    return FRAME_COUNT;
  endfunction

  task automatic fill_tlb(input int pg, input int fr);
    int slot;
    slot         = tlb_next % TLB_ENTRIES;
    tlb_pg[slot] = VPAGE_W'(pg);
    tlb_fr[slot] = FRAME_W'(fr);
    tlb_v[slot]  = 1'b1;
    tlb_next     = (slot + 1) % TLB_ENTRIES;
  endtask

  // Applies one request to the shadow state and queues the word it yields.
  task automatic resolve_request(input logic [1:0] func, input logic [15:0] va,
                                 input logic [5:0] vp);
    outcome_t r;
    int       pg, off, fr;
    bit       found;
    r     = '0;
    found = 1'b0;
    fr    = 0;
    case (func)
      FUNC_TRANSLATE: begin
        pg       = (va >> OFFSET_BITS) % PAGE_COUNT;
        off      = va & ((1 << OFFSET_BITS) - 1);
        accesses = count_up(accesses);
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (!found && tlb_v[i] && tlb_pg[i] == pg) begin
            found = 1'b1;
            fr    = tlb_fr[i];
          end
        end
        if (found) begin
          hits     = count_up(hits);
          r.status = RES_TLB_HIT;
        end else if (tbl_v[pg]) begin
          fr = tbl_fr[pg];
          fill_tlb(pg, fr);
          r.status = RES_TABLE_HIT;
        end else begin
          faults = count_up(faults);
          fr     = first_free_frame();
          if (fr < FRAME_COUNT) begin
            frame_busy[fr] = 1'b1;
            tbl_v[pg]      = 1'b1;
            tbl_fr[pg]     = FRAME_W'(fr);
            fill_tlb(pg, fr);
            r.status = RES_FAULT_OK;
          end else begin
            r.status = RES_FAULT_NO_FRAME;
          end
        end
        if (r.status != RES_FAULT_NO_FRAME) begin
          r.paddr = PADDR_W'((fr << OFFSET_BITS) | off);
          r.frame = FRAME_W'(fr);
        end
      end
      FUNC_MAP: begin
        pg = vp % PAGE_COUNT;
        fr = first_free_frame();
        if (fr < FRAME_COUNT) begin
          frame_busy[fr] = 1'b1;
          tbl_v[pg]      = 1'b1;
          tbl_fr[pg]     = FRAME_W'(fr);
          r.status       = RES_MAPPED;
          r.frame        = FRAME_W'(fr);
        end else begin
          r.status = RES_MAP_NO_FRAME;
        end
      end
      FUNC_RELEASE: begin
        // pointer survives a release
        foreach (tbl_v[i]) tbl_v[i] = 1'b0;
        foreach (frame_busy[i]) frame_busy[i] = 1'b0;
        foreach (tlb_v[i]) tlb_v[i] = 1'b0;
        hits     = '0;
        faults   = '0;
        accesses = '0;
        r.status = RES_RELEASED;
      end
      default: return;  // spare code: no word
    endcase
    r.hits     = hits;
    r.faults   = faults;
    r.accesses = accesses;
    outcome_q.push_back(r);
  endtask

  task automatic flag(input string msg);
    errors++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want)
      flag($sformatf("%s expected %0d, actual %0d", name, want, got));
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      foreach (tlb_v[i]) begin
        tlb_v[i]  = 1'b0;
        tlb_pg[i] = '0;
        tlb_fr[i] = '0;
      end
      foreach (tbl_v[i]) tbl_v[i] = 1'b0;
      foreach (frame_busy[i]) frame_busy[i] = 1'b0;
      tlb_next = 0;
      hits     = '0;
      faults   = '0;
      accesses = '0;
      outcome_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (outcome_q.size() == 0) begin
          flag($sformatf("result word with none expected: status %0d data %h",
                         m_tuser, m_tdata));
        end else begin
          want = outcome_q.pop_front();
          check_field("status",           want.status,   m_tuser);
          check_field("physical_address", want.paddr,    m_tdata[13:0]);
          check_field("frame",            want.frame,    m_tdata[17:14]);
          check_field("tlb_hit_count",    want.hits,     m_tdata[33:18]);
          check_field("fault_count",      want.faults,   m_tdata[49:34]);
          check_field("access_count",     want.accesses, m_tdata[65:50]);
        end
      end
      if (s_tvalid && s_tready)
        resolve_request(s_tuser, s_tdata[15:0], s_tdata[21:16]);
    end
    outstanding = outcome_q.size();
  end

endmodule

/* tb/sv/tlb_page_translator_core_test.sv */
// ----------------------------------------------------------------------------
// tlb_page_translator_core_test
// Drives translate, map and release words into the translator with random
// idling on both channels; the checker beside the block holds the verdict.
// ----------------------------------------------------------------------------
module tlb_page_translator_core_test;
  import tpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // func code the block drops without a word
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1000;
  localparam int SAT_ROUNDS   = 48;  // fault/hit pairs with every frame taken

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [15:0] virtual_address, [21:16] virtual_page
  logic [1:0]  s_tuser = '0;   // [1:0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // [13:0] pa, [17:14] frame, [33:18] hits,
                               // [49:34] faults, [65:50] accesses
  logic [2:0]  m_tuser;        // [2:0] status
  int          errors;
  int          outstanding;

  bit          no_idle = 1'b0; // both sides run flat out while set
  int          ready_hold = 0;
  int          item_count = 0; // words that yield a result

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tlb_page_translator_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  tlb_page_translator_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Mostly short pauses, now and then a long one.
  function automatic int pause_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] page_addr(int pg, int off);
    return 16'((pg << OFFSET_BITS_DEF) | (off & ((1 << OFFSET_BITS_DEF) - 1)));
  endfunction

  // One request word: optional idle gap, then hold tvalid until taken.
  // Returns at the falling edge after the handshake with tvalid still high.
  task automatic push_request(input logic [1:0] f, input logic [15:0] va,
                              input logic [5:0] vp);
    int gap;
    gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : pause_len();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = f;
    s_tdata  = {2'b00, vp, va};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (f != FUNC_SPARE) item_count++;
  endtask

  // Hold off the sender until every queued result has come out.
  task automatic settle();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Result side: alternating ready runs and stalls.
  always @(negedge clk) begin
    if (rst || no_idle) begin
      m_tready   <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      m_tready   <= ~m_tready;
      ready_hold <= m_tready ? pause_len() - 1 : $urandom_range(0, 15);
    end
  end

  initial begin : stimulus
    logic [5:0] ws [24];
    int         ws_size, len, r, pg;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed: extremes, stale TLB after remap, spare code, release ---
    push_request(FUNC_TRANSLATE, 16'h0000, 6'h00);  // fault, frame 0
    push_request(FUNC_TRANSLATE, 16'h03FF, 6'h00);  // TLB hit, top offset
    push_request(FUNC_TRANSLATE, 16'hFFFF, 6'h3F);  // top page faults in
    push_request(FUNC_TRANSLATE, 16'hFC00, 6'h00);
    push_request(FUNC_MAP,       16'h0000, 6'h3F);  // remap live page
    push_request(FUNC_TRANSLATE, 16'hFC01, 6'h00);  // TLB still has old frame
    push_request(FUNC_MAP,       16'hFFFF, 6'h05);
    push_request(FUNC_TRANSLATE, 16'h1555, 6'h2A);  // table hit fills TLB
    push_request(FUNC_TRANSLATE, 16'h1400, 6'h15);
    push_request(FUNC_SPARE,     16'hFFFF, 6'h3F);  // dropped
    push_request(FUNC_MAP,       16'h0000, 6'h00);
    push_request(FUNC_TRANSLATE, 16'h0155, 6'h00);
    push_request(FUNC_RELEASE,   16'hAAAA, 6'h2A);
    push_request(FUNC_TRANSLATE, 16'h0000, 6'h00);  // TLB flushed: fault
    push_request(FUNC_TRANSLATE, 16'hAAAA, 6'h15);
    push_request(FUNC_TRANSLATE, 16'h5555, 6'h2A);
    push_request(FUNC_MAP,       16'h5555, 6'h3F);
    push_request(FUNC_TRANSLATE, 16'hFFFF, 6'h3F);
    settle();

    // --- random episodes over a small working set of pages ---
    while (item_count < RANDOM_ITEMS + 18) begin
      ws_size = $urandom_range(2, 24);
      foreach (ws[i]) ws[i] = 6'($urandom);
      len     = $urandom_range(40, 150);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < len; n++) begin
        r  = $urandom_range(0, 99);
        pg = ws[$urandom_range(0, ws_size - 1)];
        if (r < 60)
          push_request(FUNC_TRANSLATE, page_addr(pg, $urandom), 6'($urandom));
        else if (r < 70)
          push_request(FUNC_TRANSLATE, 16'($urandom), 6'($urandom));
        else if (r < 85)
          push_request(FUNC_MAP, 16'($urandom), (r[0]) ? 6'($urandom) : 6'(pg));
        else if (r < 88)
          push_request(FUNC_RELEASE, 16'($urandom), 6'($urandom));
        else if (r < 93)
          push_request(FUNC_SPARE, 16'($urandom), 6'($urandom));
        else
          push_request(FUNC_TRANSLATE, page_addr(pg, r[0] ? -1 : 0), 6'($urandom));
      end
      no_idle = 1'b0;
      if ($urandom_range(0, 2) == 0) settle();
    end

    // --- frames exhausted: faults with no frame beside steady hits ---
    settle();
    no_idle = 1'b1;
    push_request(FUNC_RELEASE, 16'h0000, 6'h00);
    for (int p = 0; p < 16; p++)
      push_request(FUNC_MAP, 16'($urandom), 6'(p));
    push_request(FUNC_MAP, 16'($urandom), 6'd20);  // no frame left
    for (int i = 0; i < SAT_ROUNDS; i++) begin
      push_request(FUNC_TRANSLATE, page_addr(16 + i % 48, i), 6'h00);
      push_request(FUNC_TRANSLATE, page_addr(i % 16, $urandom), 6'h00);
    end
    push_request(FUNC_RELEASE, 16'hFFFF, 6'h3F);    // counters back to zero
    push_request(FUNC_TRANSLATE, 16'h0400, 6'h00);
    no_idle = 1'b0;

    settle();
    // a release still sweeping the table may hide a late stray word
    repeat (PAGE_COUNT_DEF + 8) @(negedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
